// ----- design/sprite_animation_sequencer_defines.svh -----
// Assertion helpers used by the RTL (included by sas_back)
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SAS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sas: check failed");

// next-cycle implication
`define SAS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sas: check failed");

`endif

// ----- design/sas_pkg.sv -----
package sas_pkg;

  localparam int unsigned NumSequencesDefault = 16;
  localparam int unsigned QueueDepth          = 2;

  localparam int unsigned IdxW     = 4;
  localparam int unsigned FrameW   = 8;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned CellW    = 12;
  localparam int unsigned ColW     = 13;
  localparam int unsigned RowW     = 14;
  localparam int unsigned DimW     = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdLoad   = 2'd1,
    CmdSelect = 2'd2,
    CmdFrame  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth   = 2'd0,
    CfgFrameHeight  = 2'd1,
    CfgFramesPerRow = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [ColW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [IdxW-1:0]     seq_index;
    logic                idx_ok;
    logic [ElapsedW-1:0] elapsed_ms;
    logic [FrameW-1:0]   frames_long;
    logic [PeriodW-1:0]  ms_per_frame;
    logic                ping_pong;
    logic [CellW-1:0]    start_col;
    logic [CellW-1:0]    start_row;
    logic                restart;
    logic [FrameW-1:0]   frame_index;
  } op_t;

  typedef struct packed {
    logic [FrameW-1:0]  len;
    logic [PeriodW-1:0] period;
    logic               bounce;
    logic [CellW-1:0]   col;
    logic [CellW-1:0]   row;
    logic [FrameW-1:0]  frame;
    logic [TimeW-1:0]   time_acc;
    logic               fwd;
  } entry_t;

  typedef struct packed {
    logic [FrameW-1:0] cur_frame;
    logic [IdxW-1:0]   cur_seq;
    logic [CoordW-1:0] src_x;
    logic [CoordW-1:0] src_y;
    logic              restart_flag;
    logic              error;
  } res_t;

endpackage

// ----- design/sas_fifo.sv -----
module sas_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = sas_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/sas_front.sv -----
module sas_front #(
  parameter int unsigned NUM_SEQUENCES = sas_pkg::NumSequencesDefault
) (
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [1:0]                      cmd_i,
  input  logic [sas_pkg::ElapsedW-1:0]    elapsed_ms_i,
  input  logic [sas_pkg::IdxW-1:0]        seq_index_i,
  input  logic [sas_pkg::FrameW-1:0]      frames_long_i,
  input  logic [sas_pkg::PeriodW-1:0]     ms_per_frame_i,
  input  logic                            ping_pong_i,
  input  logic [sas_pkg::CellW-1:0]       start_col_i,
  input  logic [sas_pkg::CellW-1:0]       start_row_i,
  input  logic                            restart_i,
  input  logic [sas_pkg::FrameW-1:0]      frame_index_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output sas_pkg::op_t                    op_o
);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    op_o              = '0;
    op_o.cmd          = sas_pkg::cmd_e'(cmd_i);
    op_o.seq_index    = seq_index_i;
    op_o.idx_ok       = (32'(seq_index_i) < 32'(NUM_SEQUENCES));
    op_o.elapsed_ms   = elapsed_ms_i;
    op_o.frames_long  = frames_long_i;
    op_o.ms_per_frame = ms_per_frame_i;
    op_o.ping_pong    = ping_pong_i;
    op_o.start_col    = start_col_i;
    op_o.start_row    = start_row_i;
    op_o.restart      = restart_i;
    op_o.frame_index  = frame_index_i;
    // only the fields a command uses travel down the queue
    case (op_o.cmd)
      sas_pkg::CmdTick: begin
        op_o.frames_long  = '0;
        op_o.ms_per_frame = '0;
        op_o.ping_pong    = 1'b0;
        op_o.start_col    = '0;
        op_o.start_row    = '0;
        op_o.restart      = 1'b0;
        op_o.frame_index  = '0;
      end
      sas_pkg::CmdLoad: begin
        op_o.elapsed_ms  = '0;
        op_o.restart     = 1'b0;
        op_o.frame_index = '0;
      end
      sas_pkg::CmdSelect: begin
        op_o.elapsed_ms   = '0;
        op_o.frames_long  = '0;
        op_o.ms_per_frame = '0;
        op_o.ping_pong    = 1'b0;
        op_o.start_col    = '0;
        op_o.start_row    = '0;
        op_o.frame_index  = '0;
      end
      sas_pkg::CmdFrame: begin
        op_o.elapsed_ms   = '0;
        op_o.frames_long  = '0;
        op_o.ms_per_frame = '0;
        op_o.ping_pong    = 1'b0;
        op_o.start_col    = '0;
        op_o.start_row    = '0;
        op_o.restart      = 1'b0;
      end
      default: begin
        op_o.idx_ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/sas_div.sv -----
module sas_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [sas_pkg::ColW-1:0] dividend_i,
  input  logic [sas_pkg::ColW-1:0] divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [sas_pkg::ColW-1:0] quotient_o,
  output logic [sas_pkg::ColW-1:0] remainder_o
);

  localparam int unsigned W    = sas_pkg::ColW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    dvd_q, dvs_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      trial, diff;
  logic            qbit;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = !diff[W];

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[W-1:0] : trial[W-1:0];
      dvd_q <= {dvd_q[W-2:0], qbit};
    end
  end

endmodule

// ----- design/sas_back.sv -----
`include "sprite_animation_sequencer_defines.svh"

module sas_back #(
  parameter int unsigned NUM_SEQUENCES = sas_pkg::NumSequencesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sas_pkg::cfg_wr_t cfg_i,
  input  sas_pkg::op_t     op_i,
  input  logic             op_empty_i,
  output logic             op_pop_o,
  output sas_pkg::res_t    res_o,
  input  logic             res_full_i,
  output logic             res_push_o
);

  localparam int unsigned IW    = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int unsigned ColW  = sas_pkg::ColW;
  localparam int unsigned RowW  = sas_pkg::RowW;
  localparam int unsigned DimW  = sas_pkg::DimW;
  localparam int unsigned TimeW = sas_pkg::TimeW;
  localparam int unsigned CrdW  = sas_pkg::CoordW;
  localparam int unsigned FrW   = sas_pkg::FrameW;
  localparam int unsigned PxW   = ColW + DimW;
  localparam int unsigned PyW   = RowW + DimW;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StExec    = 7'b0000010,
    StTick    = 7'b0000100,
    StDivGo   = 7'b0001000,
    StDivWait = 7'b0010000,
    StMul     = 7'b0100000,
    StOut     = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  sas_pkg::op_t             op_q, op_d;
  sas_pkg::entry_t          seq_mem_q [NUM_SEQUENCES];
  sas_pkg::entry_t          rd_q, w_q, w_d, new_e, mem_wr_data;
  logic                     wv_q, wv_d, err_q, err_d, restart_q, restart_d;
  logic [sas_pkg::IdxW-1:0] active_q, active_d;
  logic [NUM_SEQUENCES-1:0] loaded_q, loaded_d;
  logic [DimW-1:0]          fw_q, fh_q;
  logic [ColW-1:0]          fpr_q, fpr_eff, col_sum;
  logic [CrdW-1:0]          x_q, x_d, y_q, y_d;
  logic [IW-1:0]            act_ix, rd_addr, mem_wr_addr;
  logic                     rd_en, mem_wr_en, head_sel_ok, sel_ok, act_loaded;
  logic [TimeW:0]           sum_t;
  logic [TimeW-1:0]         tsat;
  logic [FrW:0]             len9, f9;
  logic                     div_start, div_busy, div_done;
  logic [ColW-1:0]          div_quo, div_rem;
  logic [RowW-1:0]          row_sum;
  logic [PxW-1:0]           prod_x;
  logic [PyW-1:0]           prod_y;

  assign act_ix      = IW'(active_q);
  assign act_loaded  = loaded_q[act_ix];
  assign head_sel_ok = (op_i.cmd == sas_pkg::CmdSelect) && op_i.idx_ok &&
                       loaded_q[IW'(op_i.seq_index)];
  assign sel_ok      = op_q.idx_ok && loaded_q[IW'(op_q.seq_index)];

  always_comb begin
    new_e          = '0;
    new_e.len      = op_q.frames_long;
    new_e.period   = op_q.ms_per_frame;
    new_e.bounce   = op_q.ping_pong;
    new_e.col      = op_q.start_col;
    new_e.row      = op_q.start_row;
    new_e.frame    = '0;
    new_e.time_acc = '0;
    new_e.fwd      = 1'b1;
  end

  assign sum_t = {1'b0, rd_q.time_acc} + (TimeW + 1)'(op_q.elapsed_ms);
  assign tsat  = sum_t[TimeW] ? '1 : sum_t[TimeW-1:0];
  assign len9  = (w_q.len == '0) ? (FrW + 1)'(1) : {1'b0, w_q.len};
  assign f9    = {1'b0, w_q.frame} + (FrW + 1)'(1);

  assign fpr_eff = (fpr_q == '0) ? ColW'(1) : fpr_q;
  assign col_sum = wv_q ? ColW'(w_q.col) + ColW'(w_q.frame) : '0;
  assign row_sum = wv_q ? RowW'(w_q.row) + RowW'(div_quo) : '0;
  assign prod_x  = PxW'(div_rem) * PxW'(fw_q);
  assign prod_y  = PyW'(row_sum) * PyW'(fh_q);

  sas_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (col_sum),
    .divisor_i   (fpr_eff),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    sas_pkg::entry_t e;
    e           = w_q;
    state_d     = state_q;
    op_d        = op_q;
    w_d         = w_q;
    wv_d        = wv_q;
    err_d       = err_q;
    active_d    = active_q;
    restart_d   = restart_q;
    loaded_d    = loaded_q;
    x_d         = x_q;
    y_d         = y_q;
    op_pop_o    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = act_ix;
    mem_wr_en   = 1'b0;
    mem_wr_addr = act_ix;
    mem_wr_data = w_q;
    div_start   = 1'b0;
    res_push_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (!op_empty_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          rd_en    = 1'b1;
          err_d    = 1'b0;
          state_d  = StExec;
          if (head_sel_ok) begin
            rd_addr = IW'(op_i.seq_index);
          end
        end
      end
      StExec: begin
        state_d = StDivGo;
        w_d     = rd_q;
        wv_d    = act_loaded;
        case (op_q.cmd)
          sas_pkg::CmdTick: begin
            w_d.time_acc = tsat;
            if (act_loaded) begin
              state_d = StTick;
            end
          end
          sas_pkg::CmdLoad: begin
            if (op_q.idx_ok) begin
              mem_wr_en                         = 1'b1;
              mem_wr_addr                       = IW'(op_q.seq_index);
              mem_wr_data                       = new_e;
              loaded_d[IW'(op_q.seq_index)]     = 1'b1;
              if (op_q.seq_index == active_q) begin
                w_d  = new_e;
                wv_d = 1'b1;
              end
            end
          end
          sas_pkg::CmdSelect: begin
            if (sel_ok) begin
              active_d = op_q.seq_index;
              wv_d     = 1'b1;
              if (op_q.restart) begin
                e            = rd_q;
                e.frame      = '0;
                e.time_acc   = '0;
                w_d          = e;
                mem_wr_en    = 1'b1;
                mem_wr_addr  = IW'(op_q.seq_index);
                mem_wr_data  = e;
              end
            end else begin
              err_d = 1'b1;
            end
          end
          sas_pkg::CmdFrame: begin
            if (act_loaded && ((FrW + 1)'(op_q.frame_index) <
                ((rd_q.len == '0) ? (FrW + 1)'(1) : {1'b0, rd_q.len}))) begin
              e           = rd_q;
              e.frame     = op_q.frame_index;
              w_d         = e;
              mem_wr_en   = 1'b1;
              mem_wr_data = e;
            end
          end
          default: begin
            state_d = StDivGo;
          end
        endcase
      end
      StTick: begin
        if (w_q.time_acc >= TimeW'(w_q.period)) begin
          e.time_acc = w_q.time_acc - TimeW'(w_q.period);
          if (w_q.bounce) begin
            if (w_q.fwd) begin
              if (f9 >= len9) begin
                e.fwd   = 1'b0;
                e.frame = FrW'(len9 - (FrW + 1)'(1));
              end else begin
                e.frame = f9[FrW-1:0];
              end
            end else begin
              if (w_q.frame <= FrW'(1)) begin
                e.frame   = '0;
                e.fwd     = 1'b1;
                restart_d = 1'b1;
              end else begin
                e.frame = w_q.frame - FrW'(1);
              end
            end
          end else begin
            if (f9 >= len9) begin
              e.frame   = '0;
              restart_d = 1'b1;
            end else begin
              e.frame = f9[FrW-1:0];
            end
          end
        end
        w_d         = e;
        mem_wr_en   = 1'b1;
        mem_wr_data = e;
        state_d     = StDivGo;
      end
      StDivGo: begin
        div_start = 1'b1;
        state_d   = StDivWait;
      end
      StDivWait: begin
        if (div_done) begin
          state_d = StMul;
        end
      end
      StMul: begin
        x_d     = (|prod_x[PxW-1:CrdW]) ? '1 : prod_x[CrdW-1:0];
        y_d     = (|prod_y[PyW-1:CrdW]) ? '1 : prod_y[CrdW-1:0];
        state_d = StOut;
      end
      StOut: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.cur_frame    = wv_q ? w_q.frame : '0;
    res_o.cur_seq      = active_q;
    res_o.src_x        = x_q;
    res_o.src_y        = y_q;
    res_o.restart_flag = restart_q;
    res_o.error        = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      active_q  <= '0;
      restart_q <= 1'b0;
      loaded_q  <= '0;
      err_q     <= 1'b0;
      wv_q      <= 1'b0;
      fw_q      <= DimW'(16);
      fh_q      <= DimW'(16);
      fpr_q     <= ColW'(1);
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      restart_q <= restart_d;
      loaded_q  <= loaded_d;
      err_q     <= err_d;
      wv_q      <= wv_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          sas_pkg::CfgFrameWidth:   fw_q  <= cfg_i.data[DimW-1:0];
          sas_pkg::CfgFrameHeight:  fh_q  <= cfg_i.data[DimW-1:0];
          sas_pkg::CfgFramesPerRow: fpr_q <= cfg_i.data;
          default: begin
            fpr_q <= fpr_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    w_q  <= w_d;
    x_q  <= x_d;
    y_q  <= y_d;
  end

  // sequence table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      seq_mem_q[mem_wr_addr] <= mem_wr_data;
    end
    if (rd_en) begin
      rd_q <= seq_mem_q[rd_addr];
    end
  end

  `SAS_ASSERT_IMP(a_wr_in_exec, mem_wr_en, (state_q == StExec) || (state_q == StTick))
  `SAS_ASSERT_IMP(a_push_room, res_push_o, !res_full_i && (state_q == StOut))
  `SAS_ASSERT_NXT(a_sel_loaded, (state_q == StExec) && (op_q.cmd == sas_pkg::CmdSelect) && sel_ok, loaded_q[IW'(active_q)] && (active_q == $past(op_q.seq_index)))
  `SAS_ASSERT_IMP(a_div_idle, div_start, !div_busy && !div_done)

endmodule

// ----- design/sprite_animation_sequencer.sv -----
// Sprite animation sequencer: commands (tick, load, select, set frame) enter through a
// two-deep command queue and each returns one result (active frame, active sequence,
// source rectangle origin, sticky restart flag, select error) through a two-deep result
// queue. Items are executed one at a time; each passes from the command queue to the
// result queue through the sequence table read, the update and write-back (with a
// frame step for a tick on a loaded sequence), the 13-step shift-subtract divider
// that splits the frame cell into column and row by frames_per_row, and the multiply
// into texel coordinates. Configuration writes are always accepted and belong only to
// idle periods.
module sprite_animation_sequencer #(
  parameter int unsigned NUM_SEQUENCES = sas_pkg::NumSequencesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       cmd_i,
  input  logic [sas_pkg::ElapsedW-1:0]     elapsed_ms_i,
  input  logic [sas_pkg::IdxW-1:0]         seq_index_i,
  input  logic [sas_pkg::FrameW-1:0]       frames_long_i,
  input  logic [sas_pkg::PeriodW-1:0]      ms_per_frame_i,
  input  logic                             ping_pong_i,
  input  logic [sas_pkg::CellW-1:0]        start_col_i,
  input  logic [sas_pkg::CellW-1:0]        start_row_i,
  input  logic                             restart_i,
  input  logic [sas_pkg::FrameW-1:0]       frame_index_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [sas_pkg::FrameW-1:0]       cur_frame_o,
  output logic [sas_pkg::IdxW-1:0]         cur_seq_o,
  output logic [sas_pkg::CoordW-1:0]       src_x_o,
  output logic [sas_pkg::CoordW-1:0]       src_y_o,
  output logic                             restart_flag_o,
  output logic                             error_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sas_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sas_pkg::ColW-1:0]         cfg_data_i
);

  localparam int unsigned OpW  = $bits(sas_pkg::op_t);
  localparam int unsigned ResW = $bits(sas_pkg::res_t);

  sas_pkg::op_t     fe_op, be_op;
  sas_pkg::res_t    be_res, out_res;
  sas_pkg::cfg_wr_t cfg_wr;
  logic             cq_push, cq_full, cq_pop, cq_empty;
  logic             rq_push, rq_full;
  logic [OpW-1:0]   cq_data;
  logic [ResW-1:0]  rq_data;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  sas_front #(
    .NUM_SEQUENCES (NUM_SEQUENCES)
  ) u_front (
    .push_i         (push),
    .full_o         (full),
    .cmd_i          (cmd_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .seq_index_i    (seq_index_i),
    .frames_long_i  (frames_long_i),
    .ms_per_frame_i (ms_per_frame_i),
    .ping_pong_i    (ping_pong_i),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .restart_i      (restart_i),
    .frame_index_i  (frame_index_i),
    .q_full_i       (cq_full),
    .q_push_o       (cq_push),
    .op_o           (fe_op)
  );

  sas_fifo #(
    .DATA_W (OpW),
    .DEPTH  (sas_pkg::QueueDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (fe_op),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_data),
    .empty_o (cq_empty)
  );

  assign be_op = sas_pkg::op_t'(cq_data);

  sas_back #(
    .NUM_SEQUENCES (NUM_SEQUENCES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .op_i       (be_op),
    .op_empty_i (cq_empty),
    .op_pop_o   (cq_pop),
    .res_o      (be_res),
    .res_full_i (rq_full),
    .res_push_o (rq_push)
  );

  sas_fifo #(
    .DATA_W (ResW),
    .DEPTH  (sas_pkg::QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (be_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_data),
    .empty_o (empty)
  );

  assign out_res        = sas_pkg::res_t'(rq_data);
  assign cur_frame_o    = out_res.cur_frame;
  assign cur_seq_o      = out_res.cur_seq;
  assign src_x_o        = out_res.src_x;
  assign src_y_o        = out_res.src_y;
  assign restart_flag_o = out_res.restart_flag;
  assign error_o        = out_res.error;

endmodule

// ----- tb/sv/tb_sprite_animation_sequencer.sv -----
`timescale 1ns / 100ps

module tb_sprite_animation_sequencer;

  typedef struct {
    sas_pkg::cmd_e cmd;
    logic [15:0]  elapsed;
    logic [3:0]   idx;
    logic [7:0]   len;
    logic [15:0]  period;
    logic         bounce;
    logic [11:0]  col;
    logic [11:0]  row;
    logic         restart;
    logic [7:0]   frame;
  } anim_cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         push = 1'b0;
  logic         full;
  logic [1:0]   cmd_i = sas_pkg::CmdTick;
  logic [15:0]  elapsed_ms_i = '0;
  logic [3:0]   seq_index_i = '0;
  logic [7:0]   frames_long_i = '0;
  logic [15:0]  ms_per_frame_i = '0;
  logic         ping_pong_i = 1'b0;
  logic [11:0]  start_col_i = '0;
  logic [11:0]  start_row_i = '0;
  logic         restart_i = 1'b0;
  logic [7:0]   frame_index_i = '0;
  logic         empty;
  logic         pop = 1'b0;
  logic [7:0]   cur_frame_o;
  logic [3:0]   cur_seq_o;
  logic [15:0]  src_x_o;
  logic [15:0]  src_y_o;
  logic         restart_flag_o;
  logic         error_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = sas_pkg::CfgFrameWidth;
  logic [12:0]  cfg_data_i = '0;

  sprite_animation_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .seq_index_i    (seq_index_i),
    .frames_long_i  (frames_long_i),
    .ms_per_frame_i (ms_per_frame_i),
    .ping_pong_i    (ping_pong_i),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .restart_i      (restart_i),
    .frame_index_i  (frame_index_i),
    .empty          (empty),
    .pop            (pop),
    .cur_frame_o    (cur_frame_o),
    .cur_seq_o      (cur_seq_o),
    .src_x_o        (src_x_o),
    .src_y_o        (src_y_o),
    .restart_flag_o (restart_flag_o),
    .error_o        (error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // animation table mirror
  logic [7:0]   seq_len    [16] = '{default: '0};
  logic [15:0]  seq_period [16] = '{default: '0};
  logic         seq_bounce [16] = '{default: 1'b0};
  logic [11:0]  seq_col    [16] = '{default: '0};
  logic [11:0]  seq_row    [16] = '{default: '0};
  logic [7:0]   seq_frame  [16] = '{default: '0};
  logic [31:0]  seq_time   [16] = '{default: '0};
  logic         seq_fwd    [16] = '{default: 1'b0};
  logic         seq_live   [16] = '{default: 1'b0};
  logic [3:0]   act_seq = '0;
  logic         wrap_seen = 1'b0;
  logic [7:0]   cfg_fw = 8'd16;
  logic [7:0]   cfg_fh = 8'd16;
  logic [12:0]  cfg_fpr = 13'd1;

  anim_cmd_t     tx_q[$];
  anim_cmd_t     tx_cur;
  sas_pkg::res_t sprite_rect_q[$];
  int unsigned  tx_gap = 0;
  int unsigned  rx_gap = 0;
  logic         tx_calm = 1'b0;
  logic         rx_calm = 1'b0;
  int unsigned  n_issued = 0;
  int unsigned  n_sent = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_refused = 0;
  int unsigned  n_settings = 0;
  int unsigned  n_fail = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb_sprite_animation_sequencer: FAIL");
    $finish;
  end

  function automatic sas_pkg::res_t animate(input anim_cmd_t c);
    sas_pkg::res_t r;
    logic [3:0]  s;
    logic [31:0] t;
    int unsigned len, f, fpr, col_lin, row, px, py;
    r = '0;
    s = act_seq;
    case (c.cmd)
      sas_pkg::CmdTick: begin
        if (seq_live[s]) begin
          t = (seq_time[s] > 32'hFFFF_FFFF - 32'(c.elapsed)) ? 32'hFFFF_FFFF
                                                              : seq_time[s] + 32'(c.elapsed);
          if (t >= 32'(seq_period[s])) begin
            t = t - 32'(seq_period[s]);
            len = (seq_len[s] == 8'd0) ? 1 : 32'(seq_len[s]);
            f = 32'(seq_frame[s]);
            if (seq_bounce[s] && seq_fwd[s]) begin
              if (f + 1 >= len) begin
                seq_fwd[s] = 1'b0;
                f = len - 1;
              end else begin
                f = f + 1;
              end
            end else if (seq_bounce[s]) begin
              if (f <= 1) begin
                f = 0;
                seq_fwd[s] = 1'b1;
                wrap_seen = 1'b1;
              end else begin
                f = f - 1;
              end
            end else if (f + 1 >= len) begin
              f = 0;
              wrap_seen = 1'b1;
            end else begin
              f = f + 1;
            end
            seq_frame[s] = f[7:0];
          end
          seq_time[s] = t;
        end
      end
      sas_pkg::CmdLoad: begin
        seq_len[c.idx] = c.len;
        seq_period[c.idx] = c.period;
        seq_bounce[c.idx] = c.bounce;
        seq_col[c.idx] = c.col;
        seq_row[c.idx] = c.row;
        seq_frame[c.idx] = '0;
        seq_time[c.idx] = '0;
        seq_fwd[c.idx] = 1'b1;
        seq_live[c.idx] = 1'b1;
      end
      sas_pkg::CmdSelect: begin
        if (seq_live[c.idx]) begin
          act_seq = c.idx;
          if (c.restart) begin
            seq_frame[c.idx] = '0;
            seq_time[c.idx] = '0;
          end
        end else begin
          r.error = 1'b1;
          n_refused++;
        end
      end
      default: begin
        len = (seq_len[s] == 8'd0) ? 1 : 32'(seq_len[s]);
        if (seq_live[s] && 32'(c.frame) < len) seq_frame[s] = c.frame;
      end
    endcase
    s = act_seq;
    fpr = (cfg_fpr == 13'd0) ? 1 : 32'(cfg_fpr);
    col_lin = 32'(seq_col[s]) + 32'(seq_frame[s]);
    row = 32'(seq_row[s]) + col_lin / fpr;
    col_lin = col_lin % fpr;
    px = col_lin * 32'(cfg_fw);
    py = row * 32'(cfg_fh);
    r.cur_frame = seq_frame[s];
    r.cur_seq = s;
    r.src_x = (px > 65535) ? 16'hFFFF : px[15:0];
    r.src_y = (py > 65535) ? 16'hFFFF : py[15:0];
    r.restart_flag = wrap_seen;
    return r;
  endfunction

  function automatic anim_cmd_t noise_item(input sas_pkg::cmd_e k);
    anim_cmd_t c;
    c.cmd = k;
    c.elapsed = 16'($urandom);
    c.idx = 4'($urandom);
    c.len = 8'($urandom);
    c.period = 16'($urandom);
    c.bounce = 1'($urandom);
    c.col = 12'($urandom);
    c.row = 12'($urandom);
    c.restart = 1'($urandom);
    c.frame = 8'($urandom);
    return c;
  endfunction

  function automatic anim_cmd_t tick_item(input logic [15:0] ms);
    anim_cmd_t c;
    c = noise_item(sas_pkg::CmdTick);
    c.elapsed = ms;
    return c;
  endfunction

  function automatic anim_cmd_t load_item(input logic [3:0] idx, input logic [7:0] len,
                                          input logic [15:0] period, input logic bounce,
                                          input logic [11:0] col, input logic [11:0] row);
    anim_cmd_t c;
    c = noise_item(sas_pkg::CmdLoad);
    c.idx = idx;
    c.len = len;
    c.period = period;
    c.bounce = bounce;
    c.col = col;
    c.row = row;
    return c;
  endfunction

  function automatic anim_cmd_t select_item(input logic [3:0] idx, input logic restart);
    anim_cmd_t c;
    c = noise_item(sas_pkg::CmdSelect);
    c.idx = idx;
    c.restart = restart;
    return c;
  endfunction

  function automatic anim_cmd_t frame_item(input logic [7:0] fi);
    anim_cmd_t c;
    c = noise_item(sas_pkg::CmdFrame);
    c.frame = fi;
    return c;
  endfunction

  // mostly short loops with small periods so frames actually move
  function automatic anim_cmd_t rand_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return tick_item(16'($urandom_range(0, 40)));
    if (pick < 50) return noise_item(sas_pkg::CmdTick);
    if (pick < 60) return load_item(4'($urandom), 8'($urandom_range(1, 9)),
                                    16'($urandom_range(1, 24)), 1'($urandom),
                                    12'($urandom_range(0, 30)), 12'($urandom_range(0, 30)));
    if (pick < 66) return noise_item(sas_pkg::CmdLoad);
    if (pick < 84) return noise_item(sas_pkg::CmdSelect);
    if (pick < 94) return frame_item(8'($urandom_range(0, 9)));
    return noise_item(sas_pkg::CmdFrame);
  endfunction

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin : driver
    logic sending;
    if (rst_ni) begin
      sending = push;
      if (push && !full) begin
        sprite_rect_q.insert(sprite_rect_q.size(), animate(tx_cur));
        n_sent++;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        sending = 1'b0;
      end
      if (!sending) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (tx_q.size() != 0) begin
          tx_cur = tx_q.pop_front();
          cmd_i <= tx_cur.cmd;
          elapsed_ms_i <= tx_cur.elapsed;
          seq_index_i <= tx_cur.idx;
          frames_long_i <= tx_cur.len;
          ms_per_frame_i <= tx_cur.period;
          ping_pong_i <= tx_cur.bounce;
          start_col_i <= tx_cur.col;
          start_row_i <= tx_cur.row;
          restart_i <= tx_cur.restart;
          frame_index_i <= tx_cur.frame;
          sending = 1'b1;
        end
      end
      push <= sending;
    end
  end

  always @(posedge clk_i) begin : monitor
    sas_pkg::res_t want;
    logic taking;
    if (rst_ni) begin
      taking = pop;
      if (pop && !empty) begin
        if (sprite_rect_q.size() == 0) begin
          $error("result with no pending item");
          n_fail++;
        end else begin
          want = sprite_rect_q.pop_front();
          cmp_field("cur_frame", 16'(want.cur_frame), 16'(cur_frame_o));
          cmp_field("cur_seq", 16'(want.cur_seq), 16'(cur_seq_o));
          cmp_field("src_x", want.src_x, src_x_o);
          cmp_field("src_y", want.src_y, src_y_o);
          cmp_field("restart_flag", 16'(want.restart_flag), 16'(restart_flag_o));
          cmp_field("error", 16'(want.error), 16'(error_o));
        end
        n_checked++;
        rx_gap = rx_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        taking = 1'b0;
      end
      if (!taking) begin
        if (rx_gap != 0) rx_gap--;
        else taking = 1'b1;
      end
      pop <= taking;
    end
  end

  task automatic issue(input anim_cmd_t c);
    tx_q.insert(tx_q.size(), c);
    n_issued++;
  endtask

  // sender holds off until every item in flight has returned
  task automatic drain();
    while (n_checked < n_issued) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(input sas_pkg::cfg_reg_e r, input logic [12:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      sas_pkg::CfgFrameWidth:  cfg_fw = v[7:0];
      sas_pkg::CfgFrameHeight: cfg_fh = v[7:0];
      default:                 cfg_fpr = v;
    endcase
  endtask

  initial begin : stimulus
    logic [7:0]  fw, fh;
    logic [12:0] fpr;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    n_settings = 1;

    // loop timing and wrap
    issue(load_item(4'd0, 8'd4, 16'd10, 1'b0, 12'd0, 12'd0));
    issue(tick_item(16'd0));
    issue(tick_item(16'd10));
    issue(tick_item(16'd25));
    issue(tick_item(16'd0));
    issue(tick_item(16'd5));
    issue(select_item(4'd5, 1'b0));
    // ping-pong at the far corner of the sheet
    issue(load_item(4'd1, 8'd3, 16'd1, 1'b1, 12'hFFF, 12'hFFF));
    issue(select_item(4'd1, 1'b0));
    repeat (4) issue(tick_item(16'd1));
    issue(frame_item(8'd2));
    issue(frame_item(8'd255));
    // one-frame ping-pong, zero period
    issue(load_item(4'd2, 8'd1, 16'd0, 1'b1, 12'd7, 12'd0));
    issue(select_item(4'd2, 1'b1));
    repeat (2) issue(tick_item(16'd0));
    // zero length
    issue(load_item(4'd3, 8'd0, 16'hFFFF, 1'b0, 12'd100, 12'd2));
    issue(select_item(4'd3, 1'b0));
    issue(tick_item(16'hFFFF));
    issue(load_item(4'd15, 8'd255, 16'd1, 1'b0, 12'd0, 12'd0));
    issue(select_item(4'd15, 1'b1));
    issue(tick_item(16'hFFFF));
    issue(frame_item(8'd254));
    issue(tick_item(16'd0));
    issue(select_item(4'd1, 1'b1));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin fw = 8'd1;   fh = 8'd1;   fpr = 13'd1;    end
        1: begin fw = 8'd255; fh = 8'd255; fpr = 13'd4096; end
        2: begin fw = 8'd7;   fh = 8'd13;  fpr = 13'd3;    end
        3: begin fw = 8'd255; fh = 8'd1;   fpr = 13'd0;    end
        4: begin fw = 8'd16;  fh = 8'd16;  fpr = 13'd8;    end
        5: begin fw = 8'd1;   fh = 8'd255; fpr = 13'd4095; end
        default: begin
          fw = 8'($urandom_range(1, 255));
          fh = 8'($urandom_range(1, 255));
          fpr = 13'($urandom_range(1, 4096));
        end
      endcase
      write_reg(sas_pkg::CfgFrameWidth, {5'd0, fw});
      write_reg(sas_pkg::CfgFrameHeight, {5'd0, fh});
      write_reg(sas_pkg::CfgFramesPerRow, fpr);
      n_settings++;
      repeat (90) issue(rand_item());
      drain();
    end

    repeat (16) @(posedge clk_i);
    $display("%0d commands checked under %0d register settings, %0d selects refused",
             n_checked, n_settings, n_refused);
    if (n_fail == 0 && sprite_rect_q.size() == 0) begin
      $display("tb_sprite_animation_sequencer: PASS");
    end else begin
      $display("tb_sprite_animation_sequencer: FAIL");
    end
    $finish;
  end

endmodule
